FILE: src/assert_macros.svh
// assertion macros for the recency list block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: src/rlc_pkg.sv
// package for the recency list: payload structs, codes, constants
// no dependencies
`default_nettype none
package rlc_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_REMOVE = 4'd1, CMD_MOVE = 4'd2, CMD_FRONT = 4'd3,
    CMD_READ = 4'd4, CMD_SELECT = 4'd5, CMD_FWD = 4'd6, CMD_BACK = 4'd7,
    CMD_NEXT = 4'd8
  } cmd_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_RANK = 3'd1;
  localparam logic [2:0] ST_NONE = 3'd2;
  localparam logic [2:0] ST_NO_NEIGHBOR = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] ORD_ONCE = 2'd0;
  localparam logic [1:0] ORD_CYCLE = 2'd1;
  localparam logic [1:0] ORD_SHUFFLE = 2'd2;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] entry_key;
    logic        is_local;
    logic [39:0] progress_ms;
    logic [3:0]  target_rank;
    logic [3:0]  source_rank;
    logic [1:0]  play_order;
    logic [31:0] random_word;
  } cmd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  rank_result;
    logic        list_end;
    logic [31:0] key_out;
    logic        is_local_out;
    logic [39:0] progress_out;
    logic [4:0]  entry_count;
    logic [3:0]  cursor_rank;
    logic        cursor_valid;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_PUT, S_READ, S_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: src/rlc_store.sv
// entry memory: key, local flag and progress in one synchronous array
// no dependencies; rlc_pkg is not used
`default_nettype none
module rlc_store #(
  parameter int DEPTH = 16,
  parameter int W = 73
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  // one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/recency_list_with_cursor.sv
// top level of the recency list with cursor: sequencer plus entry memory
// depends on rlc_pkg, rlc_store, assert_macros.svh
//
// usage: raise start with a command struct while busy is low; the transaction is
// taken at that edge and busy rises. exactly one result appears on result for
// one cycle with done high; the receiver cannot stall it.
// command sequence from the accepting edge to the edge that takes the result:
//   select, cursor steps, next rank, unknown command or bad rank: straight to done
//   read: one registered read of the entry, then done
//   add, remove, move: shift the N entries in between one at a time
//     (each entry: read, then write); move first reads the source, add and move then place
//   key to front: scan all entries; it ends there when absent or already at rank 0;
//     when the last match sits at rank R > 0, read it, shift the ranks above it and place it
// busy falls in the cycle after done.
// at most one command is in flight. the user writes capacity with cfg_we/cfg_data only while
// idle; the block does not enforce this. reset clears the count, the cursor and the selection
// and sets capacity to 16; the memory is not cleared, only ranks below count are read.
`default_nettype none
`include "assert_macros.svh"
module recency_list_with_cursor #(
  parameter int DEPTH = rlc_pkg::DEPTH_DEF,
  parameter int KEY_BITS = rlc_pkg::KEY_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire rlc_pkg::cmd_in_t cmd,
  output logic                 busy,
  output logic                 done,
  output rlc_pkg::result_t     result,
  input  wire logic            cfg_we,
  input  wire logic [4:0]      cfg_data
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W = KEY_BITS + 41;

  rlc_pkg::state_t state, state_next;
  rlc_pkg::cmd_in_t c;
  logic [4:0] capacity;
  logic [CW-1:0] count, count_next;
  logic [3:0] cursor, cursor_next;
  logic cursor_set, cursor_set_next;
  logic [AW-1:0] idx, idx_next, stop, stop_next;
  logic dir_up, dir_up_next;
  logic [W-1:0] hold, hold_next;
  logic hold_grab;
  logic found, found_next;
  logic [AW-1:0] where, where_next;
  logic phase, phase_next;
  logic [2:0] status, status_next;
  logic [W-1:0] res_data, res_data_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0] wdata, rdata;

  rlc_store #(.DEPTH(DEPTH), .W(W)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // effective capacity and rank checks
  logic [CW:0] cap_eff;
  always_comb begin
    if (capacity == 5'd0) cap_eff = (CW+1)'(1);
    else if (32'(capacity) > DEPTH) cap_eff = (CW+1)'(DEPTH);
    else cap_eff = (CW+1)'(capacity);
  end
  wire tgt_ok = {1'b0, CW'(cmd.target_rank)} < {1'b0, count} && 32'(cmd.target_rank) < DEPTH;
  wire src_ok = {1'b0, CW'(cmd.source_rank)} < {1'b0, count} && 32'(cmd.source_rank) < DEPTH;
  wire chosen = cursor_set && {1'b0, CW'(cursor)} < {1'b0, count};
  wire [KEY_BITS-1:0] key_in = KEY_BITS'(cmd.entry_key);
  wire [W-1:0] new_entry = {key_in, cmd.is_local, cmd.progress_ms};
  wire [31+CW:0] shuf = (32+CW)'(c.random_word) * (32+CW)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlc_pkg::S_IDLE;
      capacity <= 5'd16;
      count <= '0;
      cursor <= '0;
      cursor_set <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) capacity <= cfg_data;
      count <= count_next;
      cursor <= cursor_next;
      cursor_set <= cursor_set_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) c <= cmd;
    idx <= idx_next;
    stop <= stop_next;
    dir_up <= dir_up_next;
    hold <= hold_grab ? rdata : hold_next;
    found <= found_next;
    where <= where_next;
    phase <= phase_next;
    status <= status_next;
    res_data <= res_data_next;
  end

  // sequencer: scan, read, shift (read one entry, write its neighbor), place
  always_comb begin
    state_next = state;
    count_next = count;
    cursor_next = cursor;
    cursor_set_next = cursor_set;
    idx_next = idx; stop_next = stop; dir_up_next = dir_up;
    hold_next = hold; hold_grab = 1'b0;
    found_next = found; where_next = where; phase_next = phase;
    status_next = status; res_data_next = res_data;
    we = 1'b0; waddr = idx; wdata = rdata; raddr = idx;
    busy = state != rlc_pkg::S_IDLE;
    done = 1'b0;
    result = '0;
    case (state)
      rlc_pkg::S_IDLE: begin
        if (start) begin
          status_next = rlc_pkg::ST_OK;
          res_data_next = '0;
          phase_next = 1'b0;
          state_next = rlc_pkg::S_DONE;
          case (cmd.command)
            rlc_pkg::CMD_ADD: begin
              hold_next = new_entry;
              dir_up_next = 1'b0;
              stop_next = '0;
              if ({1'b0, count} < cap_eff) begin
                idx_next = AW'(count);
                count_next = count + CW'(1);
              end else begin
                idx_next = AW'(count - CW'(1));
              end
              state_next = rlc_pkg::S_SHIFT;
            end
            rlc_pkg::CMD_REMOVE: begin
              if (!tgt_ok) status_next = rlc_pkg::ST_BAD_RANK;
              else begin
                idx_next = AW'(cmd.target_rank);
                stop_next = AW'(count - CW'(1));
                dir_up_next = 1'b1;
                count_next = count - CW'(1);
                state_next = rlc_pkg::S_SHIFT;
              end
            end
            rlc_pkg::CMD_MOVE: begin
              if (!tgt_ok || !src_ok || cmd.target_rank == cmd.source_rank)
                status_next = rlc_pkg::ST_BAD_RANK;
              else begin
                idx_next = AW'(cmd.source_rank);
                state_next = rlc_pkg::S_READ;
              end
            end
            rlc_pkg::CMD_FRONT: begin
              found_next = 1'b0;
              idx_next = '0;
              state_next = rlc_pkg::S_SCAN;
            end
            rlc_pkg::CMD_READ: begin
              if (!tgt_ok) status_next = rlc_pkg::ST_BAD_RANK;
              else begin
                idx_next = AW'(cmd.target_rank);
                state_next = rlc_pkg::S_READ;
              end
            end
            rlc_pkg::CMD_SELECT: begin
              if (!tgt_ok) status_next = rlc_pkg::ST_BAD_RANK;
              else begin
                cursor_next = cmd.target_rank;
                cursor_set_next = 1'b1;
              end
            end
            rlc_pkg::CMD_FWD: begin
              if (!chosen) status_next = rlc_pkg::ST_NONE;
              else if ({1'b0, CW'(cursor)} + (CW+1)'(1) >= {1'b0, count})
                status_next = rlc_pkg::ST_NO_NEIGHBOR;
              else cursor_next = cursor + 4'd1;
            end
            rlc_pkg::CMD_BACK: begin
              if (!chosen) status_next = rlc_pkg::ST_NONE;
              else if (cursor == 4'd0) status_next = rlc_pkg::ST_NO_NEIGHBOR;
              else cursor_next = cursor - 4'd1;
            end
            rlc_pkg::CMD_NEXT: begin
              if (!chosen) status_next = rlc_pkg::ST_NONE;
            end
            default: ;
          endcase
        end
      end
      rlc_pkg::S_SCAN: begin
        // first cycle primes the read of rank 0, then one compare per cycle
        // while the read of the following rank is issued
        raddr = phase ? idx + AW'(1) : idx;
        phase_next = 1'b1;
        if (!phase) begin
          if (count == '0) state_next = rlc_pkg::S_DONE;
        end else begin
          if (rdata[W-1 -: KEY_BITS] == KEY_BITS'(c.entry_key)) begin
            found_next = 1'b1;
            where_next = idx;
          end
          if ({1'b0, CW'(idx)} + (CW+1)'(1) >= {1'b0, count}) state_next = rlc_pkg::S_DONE;
          else idx_next = idx + AW'(1);
        end
        if (state_next == rlc_pkg::S_DONE) begin
          if (!(found_next)) status_next = rlc_pkg::ST_NOT_FOUND;
          else if (where_next != '0) begin
            idx_next = where_next;
            state_next = rlc_pkg::S_READ;
          end
          phase_next = 1'b0;
        end
      end
      rlc_pkg::S_READ: begin
        // registered read of one entry
        raddr = idx;
        if (!phase) phase_next = 1'b1;
        else begin
          phase_next = 1'b0;
          if (c.command == rlc_pkg::CMD_READ) begin
            res_data_next = rdata;
            state_next = rlc_pkg::S_DONE;
          end else begin
            hold_grab = 1'b1;
            stop_next = (c.command == rlc_pkg::CMD_MOVE) ? AW'(c.target_rank) : '0;
            dir_up_next = (c.command == rlc_pkg::CMD_MOVE) &&
                          (c.target_rank > c.source_rank);
            state_next = rlc_pkg::S_SHIFT;
          end
        end
      end
      rlc_pkg::S_SHIFT: begin
        // copy neighbor into idx: read, then write
        raddr = dir_up ? idx + AW'(1) : idx - AW'(1);
        if (idx == stop) begin
          state_next = (c.command == rlc_pkg::CMD_REMOVE) ? rlc_pkg::S_DONE
                                                          : rlc_pkg::S_PUT;
          phase_next = 1'b0;
        end else if (!phase) phase_next = 1'b1;
        else begin
          we = 1'b1; waddr = idx; wdata = rdata;
          idx_next = dir_up ? idx + AW'(1) : idx - AW'(1);
          phase_next = 1'b0;
        end
      end
      rlc_pkg::S_PUT: begin
        we = 1'b1; waddr = idx; wdata = hold;
        state_next = rlc_pkg::S_DONE;
      end
      rlc_pkg::S_DONE: begin
        done = 1'b1;
        state_next = rlc_pkg::S_IDLE;
        result.status = status;
        result.entry_count = 5'(count);
        result.cursor_rank = cursor;
        result.cursor_valid = chosen;
        if (c.command == rlc_pkg::CMD_READ && status == rlc_pkg::ST_OK) begin
          result.key_out = 32'(res_data[W-1 -: KEY_BITS]);
          result.is_local_out = res_data[40];
          result.progress_out = res_data[39:0];
        end
        if (c.command == rlc_pkg::CMD_NEXT && status == rlc_pkg::ST_OK) begin
          case (c.play_order)
            rlc_pkg::ORD_ONCE: begin
              if ({1'b0, CW'(cursor)} + (CW+1)'(1) >= {1'b0, count}) result.list_end = 1'b1;
              else result.rank_result = cursor + 4'd1;
            end
            rlc_pkg::ORD_CYCLE:
              result.rank_result = ({1'b0, CW'(cursor)} + (CW+1)'(1) >= {1'b0, count})
                                   ? 4'd0 : cursor + 4'd1;
            rlc_pkg::ORD_SHUFFLE: result.rank_result = shuf[35:32];
            default: result.rank_result = cursor;
          endcase
        end
      end
      default: state_next = rlc_pkg::S_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_done_one, clk, rst, done, !done)
  `ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, 32'(count) <= DEPTH)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule
`default_nettype wire
